FILE: rtl/core/clconv_pkg.sv
package clconv_pkg;

  localparam int MAX_TAPS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_BITS        = 40;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_COEF = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_EMIT
  } conv_state_t;

endpackage

FILE: rtl/core/complex_linear_convolution_unit.sv
// Channel   Handshake                    Payload
// sample    sample_valid / sample_ready  kind, sample_real, sample_imag, last_of_sequence
// result    result_valid / result_ready  out_real, out_imag, end_of_run
//
// A coefficient request is taken without leaving ST_IDLE. A data request holds the input
// while the sequencer runs: one tap and one history entry are read per cycle from the two
// memories, three stages drain, and the result register is loaded in ST_EMIT.
// The last data request adds tap_count - 1 tail results.
// Reset (rst, synchronous) clears the control state only; no clearing pass.
// A full result register holds the sequencer until result_ready frees it.
module complex_linear_convolution_unit
  import clconv_pkg::*;
#(
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic                          kind,
  input  logic signed [SAMPLE_BITS-1:0] sample_real,
  input  logic signed [SAMPLE_BITS-1:0] sample_imag,
  input  logic                          last_of_sequence,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic signed [OUT_BITS-1:0]    out_real,
  output logic signed [OUT_BITS-1:0]    out_imag,
  output logic                          end_of_run
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int SB = SAMPLE_BITS;
  localparam int PW = 2 * SAMPLE_BITS;

  conv_state_t state, state_next;

  logic [2*SB-1:0] tap_mem  [MAX_TAPS];
  logic [2*SB-1:0] hist_mem [MAX_TAPS];

  logic [CW-1:0] tap_count;
  logic [CW-1:0] fill;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] k;
  logic [CW-1:0] tail_left;
  logic          loading;
  logic          last_run;

  logic          accept;
  logic          emit_ok;
  logic          push;
  logic          issue;
  logic          run_done;
  logic [AW-1:0] push_ptr;
  logic [2*SB-1:0] push_data;
  logic [CW-1:0] coef_idx;

  // multiply-accumulate pipeline
  logic              rd_vld, rd_zero;
  logic [2*SB-1:0]   tap_q, hist_q;
  logic              pr_vld, df_vld;
  logic signed [SB-1:0] h_re, h_im, s_re, s_im;
  logic signed [PW-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [OUT_BITS-1:0] d_re, d_im;
  logic signed [OUT_BITS-1:0] acc_re, acc_im;

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid && sample_ready;
  assign emit_ok      = (state == ST_EMIT) && (!result_valid || result_ready);
  assign push         = (accept && kind == KIND_DATA) || (emit_ok && tail_left != '0);
  assign run_done     = emit_ok && tail_left == '0 && last_run;
  assign issue        = (state == ST_MAC) && (k < tap_count);
  assign push_ptr     = (wr_ptr == AW'(MAX_TAPS - 1)) ? '0 : wr_ptr + 1'b1;
  assign push_data    = accept ? {sample_imag, sample_real} : '0;
  assign coef_idx     = loading ? tap_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_DATA) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (!issue && !rd_vld && !pr_vld && !df_vld) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          state_next = (tail_left != '0) ? ST_MAC : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memories
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_COEF && coef_idx < CW'(MAX_TAPS)) begin
      tap_mem[coef_idx[AW-1:0]] <= {sample_imag, sample_real};
    end
    if (issue) begin
      tap_q <= tap_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      hist_mem[push_ptr] <= push_data;
    end
    if (issue) begin
      hist_q <= hist_mem[rd_ptr];
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= '0;
      fill      <= '0;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      k         <= '0;
      tail_left <= '0;
      loading   <= 1'b0;
      last_run  <= 1'b0;
    end else begin
      if (accept && kind == KIND_COEF) begin
        if (!loading) begin
          fill   <= '0;
          wr_ptr <= '0;
        end
        if (coef_idx < CW'(MAX_TAPS)) begin
          tap_count <= coef_idx + 1'b1;
        end else begin
          tap_count <= coef_idx;
        end
        loading <= !last_of_sequence;
      end
      if (accept && kind == KIND_DATA) begin
        loading  <= 1'b0;
        last_run <= last_of_sequence;
        if (last_of_sequence && tap_count != '0) begin
          tail_left <= tap_count - 1'b1;
        end else begin
          tail_left <= '0;
        end
      end else if (emit_ok && tail_left != '0) begin
        tail_left <= tail_left - 1'b1;
      end
      if (push) begin
        wr_ptr <= push_ptr;
        rd_ptr <= push_ptr;
        k      <= '0;
        if (fill != CW'(MAX_TAPS)) begin
          fill <= fill + 1'b1;
        end
      end else if (issue) begin
        k      <= k + 1'b1;
        rd_ptr <= (rd_ptr == '0) ? AW'(MAX_TAPS - 1) : rd_ptr - 1'b1;
      end
      // drop the history once the run's final result is out
      if (run_done) begin
        fill   <= '0;
        wr_ptr <= '0;
      end
    end
  end

  // Entries older than the samples pushed this run read as zero
  assign h_re = tap_q[SB-1:0];
  assign h_im = tap_q[2*SB-1:SB];
  assign s_re = rd_zero ? '0 : hist_q[SB-1:0];
  assign s_im = rd_zero ? '0 : hist_q[2*SB-1:SB];
  assign m_rr = h_re * s_re;
  assign m_ii = h_im * s_im;
  assign m_ri = h_re * s_im;
  assign m_ir = h_im * s_re;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      pr_vld <= 1'b0;
      df_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      pr_vld <= rd_vld;
      df_vld <= pr_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_zero <= (k >= fill);
    end
    p_rr <= m_rr;
    p_ii <= m_ii;
    p_ri <= m_ri;
    p_ir <= m_ir;
    d_re <= OUT_BITS'(p_rr) - OUT_BITS'(p_ii);
    d_im <= OUT_BITS'(p_ri) + OUT_BITS'(p_ir);
    if (push) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (df_vld) begin
      acc_re <= acc_re + d_re;
      acc_im <= acc_im + d_im;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_ok) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok) begin
      out_real   <= acc_re;
      out_imag   <= acc_im;
      end_of_run <= last_run && tail_left == '0;
    end
  end

endmodule
